// ===== rtl/pvm_pkg.sv =====
// Shared constants, types and the quarter-wave sine table for the phase voltage modulator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package pvm_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int SINE_ENTRIES = 1024;
    localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
    localparam int QUARTER      = SINE_ENTRIES / 4;
    localparam int QIDX_BITS    = SINE_BITS - 2;
    localparam int Z_STEP       = 16384 / QUARTER;

    localparam logic [QIDX_BITS:0]    QUARTER_Z = QUARTER[QIDX_BITS:0];
    localparam logic [ANGLE_BITS-1:0] QTR_TURN  = ANGLE_BITS'(1 << (ANGLE_BITS - 2));

    localparam int VOLT_W    = 16;
    localparam int PERIOD_W  = 17;
    localparam int DEN_W     = VOLT_W + 14;
    localparam int NUM_W     = DEN_W + PERIOD_W;
    localparam int U_W       = 40;
    localparam int SQRT3_Q16 = 113512;

    localparam int FRONT_STAGES = 6;
    localparam int DUTY_STAGES  = 2 + PERIOD_W;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DUTY_STAGES + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_LIMIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_VOLTAGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_ANGLE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD     = 2'd3;

    typedef struct packed {
        logic force_out;
        logic full;
    } duty_flag_t;

    typedef logic [14:0] qsine_t;
    typedef qsine_t sine_tbl_t [QUARTER+1];

    // Polynomial sine over a quarter turn, z in Q14 with 16384 at a quarter turn.
    function automatic qsine_t quarter_sine(input longint unsigned z);
        longint unsigned z2;
        longint unsigned t;
        z2 = (z * z) >> 14;
        t  = (64'd1231 * z2) >> 14;
        t  = 64'd10583 - t;
        t  = (z2 * t) >> 14;
        t  = 64'd25736 - t;
        t  = (z * t) >> 14;
        if (t > 64'd16384) begin
            t = 64'd16384;
        end
        return qsine_t'(t);
    endfunction

    function automatic sine_tbl_t build_sine_tbl();
        sine_tbl_t tbl;
        for (int i = 0; i <= QUARTER; i++) begin
            tbl[i] = quarter_sine(longint'(i) * Z_STEP);
        end
        return tbl;
    endfunction

    localparam sine_tbl_t SINE_TBL = build_sine_tbl();

endpackage
`default_nettype wire

// ===== rtl/pvm_front.sv =====
// Angle offset, sine/cosine lookup, inverse Park and inverse Clarke stages (six registers).
// Depends on pvm_pkg.
`default_nettype none
module pvm_front
    import pvm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [15:0]    q_voltage,
    input  wire logic signed [15:0]    d_voltage,
    input  wire logic [15:0]           elec_angle,
    input  wire logic [15:0]           zero_angle,
    input  wire logic [VOLT_W-1:0]     supply_voltage,
    output logic signed [U_W-1:0]      ua,
    output logic signed [U_W-1:0]      ub,
    output logic signed [U_W-1:0]      uc
);

    function automatic logic signed [15:0] lookup(input logic [ANGLE_BITS-1:0] th);
        logic [SINE_BITS-1:0] k;
        logic [1:0]           quad;
        logic [QIDX_BITS:0]   zi;
        logic signed [15:0]   m;
        k    = th[ANGLE_BITS-1 -: SINE_BITS];
        quad = k[SINE_BITS-1 -: 2];
        zi   = quad[0] ? (QUARTER_Z - {1'b0, k[QIDX_BITS-1:0]}) : {1'b0, k[QIDX_BITS-1:0]};
        m    = {1'b0, SINE_TBL[zi]};
        return quad[1] ? -m : m;
    endfunction

    logic signed [15:0]     q0_reg, d0_reg, q1_reg, d1_reg;
    logic [ANGLE_BITS-1:0]  th0_reg;
    logic signed [15:0]     sin1_reg, cos1_reg;
    logic signed [31:0]     dc2_reg, qs2_reg, qc2_reg, ds2_reg;
    logic signed [32:0]     alpha3_reg, beta3_reg, alpha4_reg;
    logic signed [51:0]     prod4_reg;
    logic signed [U_W-1:0]  ua5_reg, ub5_reg, uc5_reg;
    logic signed [U_W-1:0]  ua5_next, ub5_next, uc5_next;

    always_comb begin
        logic signed [U_W-1:0] a;
        logic signed [U_W-1:0] s;
        logic signed [U_W-1:0] h;
        a = U_W'(alpha4_reg);
        s = U_W'(prod4_reg >>> 16);
        h = $signed({3'b000, supply_voltage, 21'd0});
        ua5_next = a + h;
        ub5_next = ((s - a) >>> 1) + h;
        uc5_next = ((-s - a) >>> 1) + h;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            q0_reg     <= q_voltage;
            d0_reg     <= d_voltage;
            th0_reg    <= ANGLE_BITS'(17'(elec_angle) + 17'(zero_angle));
            q1_reg     <= q0_reg;
            d1_reg     <= d0_reg;
            sin1_reg   <= lookup(th0_reg);
            cos1_reg   <= lookup(th0_reg + QTR_TURN);
            dc2_reg    <= d1_reg * cos1_reg;
            qs2_reg    <= q1_reg * sin1_reg;
            qc2_reg    <= q1_reg * cos1_reg;
            ds2_reg    <= d1_reg * sin1_reg;
            alpha3_reg <= 33'(dc2_reg) - 33'(qs2_reg);
            beta3_reg  <= 33'(qc2_reg) + 33'(ds2_reg);
            alpha4_reg <= alpha3_reg;
            prod4_reg  <= 52'(beta3_reg) * 52'sd113512;
            ua5_reg    <= ua5_next;
            ub5_reg    <= ub5_next;
            uc5_reg    <= uc5_next;
        end
    end

    assign ua = ua5_reg;
    assign ub = ub5_reg;
    assign uc = uc5_reg;

endmodule
`default_nettype wire

// ===== rtl/pvm_duty.sv =====
// One phase lane: clamp, scale by the period and a restoring divider, one quotient bit a stage.
// Depends on pvm_pkg.
`default_nettype none
module pvm_duty
    import pvm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire logic signed [U_W-1:0] u,
    input  wire logic [VOLT_W-1:0]     phase_cap,
    input  wire logic [VOLT_W-1:0]     supply_voltage,
    input  wire logic [PERIOD_W-1:0]   pwm_period,
    output logic [PERIOD_W-1:0]        quotient,
    output duty_flag_t                 flag
);

    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] top;
    logic [DEN_W-1:0] clamp_next;
    duty_flag_t       flag_next;

    logic [DEN_W-1:0] clamp_reg;
    duty_flag_t       flag_a_reg, flag_b_reg;
    logic [NUM_W-1:0] num_b_reg;

    logic [DEN_W-1:0]    rem_reg  [PERIOD_W-1];
    logic [NUM_W-1:0]    num_reg  [PERIOD_W-1];
    logic [PERIOD_W-1:0] quo_reg  [PERIOD_W];
    duty_flag_t          flg_reg  [PERIOD_W];

    assign den = {supply_voltage, 14'd0};
    assign top = {phase_cap, 14'd0};

    // When the clamped voltage reaches the divisor the duty saturates, so the
    // quotient never needs more than PERIOD_W bits.
    always_comb begin
        if (u < 0) begin
            clamp_next = '0;
        end else if (u > $signed(U_W'(top))) begin
            clamp_next = top;
        end else begin
            clamp_next = u[DEN_W-1:0];
        end
        if (supply_voltage == '0) begin
            flag_next.force_out = 1'b1;
            flag_next.full      = (clamp_next != '0);
        end else begin
            flag_next.force_out = (clamp_next >= den);
            flag_next.full      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            clamp_reg  <= clamp_next;
            flag_a_reg <= flag_next;
            num_b_reg  <= NUM_W'(clamp_reg) * NUM_W'(pwm_period);
            flag_b_reg <= flag_a_reg;
        end
    end

    for (genvar i = 0; i < PERIOD_W; i++) begin : g_div
        localparam int B = PERIOD_W - 1 - i;
        logic [DEN_W-1:0]    rem_src;
        logic [NUM_W-1:0]    num_src;
        logic [PERIOD_W-1:0] quo_src;
        duty_flag_t          flg_src;
        logic [DEN_W:0]      trial;
        logic                ge;
        logic [PERIOD_W-1:0] quo_next;

        if (i == 0) begin : g_first
            assign rem_src = num_b_reg[NUM_W-1:PERIOD_W];
            assign num_src = num_b_reg;
            assign quo_src = '0;
            assign flg_src = flag_b_reg;
        end else begin : g_rest
            assign rem_src = rem_reg[i-1];
            assign num_src = num_reg[i-1];
            assign quo_src = quo_reg[i-1];
            assign flg_src = flg_reg[i-1];
        end

        always_comb begin
            trial    = {rem_src, num_src[B]};
            ge       = (trial >= {1'b0, den});
            quo_next = quo_src;
            quo_next[B] = ge;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[i] <= quo_next;
                flg_reg[i] <= flg_src;
            end
        end

        // The last stage only needs its quotient bit; the remainder ends there.
        if (i < PERIOD_W - 1) begin : g_keep
            logic [DEN_W-1:0] rem_next;
            assign rem_next = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    num_reg[i] <= num_src;
                end
            end
        end
    end

    assign quotient = quo_reg[PERIOD_W-1];
    assign flag     = flg_reg[PERIOD_W-1];

endmodule
`default_nettype wire

// ===== rtl/phase_voltage_modulator.sv =====
// Top level of the phase voltage modulator: configuration registers, valid pipeline, lanes.
// Depends on pvm_pkg, pvm_front and pvm_duty.
//
// Usage:
//   The s_ channel takes one voltage request per cycle: q and d voltages (signed Q8.8)
//   and an electrical angle (16-bit turn fraction). The m_ channel returns three PWM
//   compare values for that request, in request order, one result per request.
//   Configuration (voltage limit, supply, zero angle, PWM period) is written through
//   cfg_wr_en / cfg_index / cfg_wdata while no request is in flight.
//   A request passes 26 register stages: six of angle lookup and transforms, two of
//   clamp and scaling, seventeen divider stages (one quotient bit each) and the output
//   register. Throughput is one request per cycle while the pipeline is not stalled.
//   When the receiver holds m_ready low with a result waiting, the whole pipeline
//   freezes and s_ready falls; nothing is dropped or repeated, and empty slots in the
//   pipeline do not block.
//   A synchronous reset (aresetn low) empties the pipeline and loads the register
//   defaults: limit 10 V, supply 12 V, zero angle 0, period 1800.
`default_nettype none
module phase_voltage_modulator
    import pvm_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed [15:0]    s_q_voltage,
    input  wire logic signed [15:0]    s_d_voltage,
    input  wire logic [15:0]           s_elec_angle,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic [PERIOD_W-1:0]        m_compare_a,
    output logic [PERIOD_W-1:0]        m_compare_b,
    output logic [PERIOD_W-1:0]        m_compare_c,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [PERIOD_W-1:0]   cfg_wdata
);

    logic [VOLT_W-1:0]     phase_cap_reg;
    logic [VOLT_W-1:0]     supply_voltage_reg;
    logic [15:0]           zero_angle_reg;
    logic [PERIOD_W-1:0]   pwm_period_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic                  adv;

    logic signed [U_W-1:0] ua, ub, uc;
    logic [PERIOD_W-1:0]   quo_a, quo_b, quo_c;
    duty_flag_t            flg_a, flg_b, flg_c;
    logic [PERIOD_W-1:0]   cmp_a_reg, cmp_b_reg, cmp_c_reg;

    assign adv     = !vld_reg[PIPE_DEPTH-1] || m_ready;
    assign s_ready = adv;
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_cap_reg      <= 16'd2560;
            supply_voltage_reg <= 16'd3072;
            zero_angle_reg     <= 16'd0;
            pwm_period_reg     <= 17'd1800;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_VOLTAGE_LIMIT:  phase_cap_reg      <= cfg_wdata[VOLT_W-1:0];
                REG_SUPPLY_VOLTAGE: supply_voltage_reg <= cfg_wdata[VOLT_W-1:0];
                REG_ZERO_ANGLE:     zero_angle_reg     <= cfg_wdata[15:0];
                REG_PWM_PERIOD:     pwm_period_reg     <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_DEPTH-2:0], s_valid};
        end
    end

    pvm_front u_front (
        .aclk           (aclk),
        .en             (adv),
        .q_voltage      (s_q_voltage),
        .d_voltage      (s_d_voltage),
        .elec_angle     (s_elec_angle),
        .zero_angle     (zero_angle_reg),
        .supply_voltage (supply_voltage_reg),
        .ua             (ua),
        .ub             (ub),
        .uc             (uc)
    );

    pvm_duty u_duty_a (
        .aclk (aclk), .en (adv), .u (ua),
        .phase_cap (phase_cap_reg), .supply_voltage (supply_voltage_reg),
        .pwm_period (pwm_period_reg), .quotient (quo_a), .flag (flg_a)
    );

    pvm_duty u_duty_b (
        .aclk (aclk), .en (adv), .u (ub),
        .phase_cap (phase_cap_reg), .supply_voltage (supply_voltage_reg),
        .pwm_period (pwm_period_reg), .quotient (quo_b), .flag (flg_b)
    );

    pvm_duty u_duty_c (
        .aclk (aclk), .en (adv), .u (uc),
        .phase_cap (phase_cap_reg), .supply_voltage (supply_voltage_reg),
        .pwm_period (pwm_period_reg), .quotient (quo_c), .flag (flg_c)
    );

    function automatic logic [PERIOD_W-1:0] pick(input logic [PERIOD_W-1:0] q,
                                                 input duty_flag_t f,
                                                 input logic [PERIOD_W-1:0] p);
        if (f.force_out) begin
            return f.full ? p : '0;
        end
        return q;
    endfunction

    always_ff @(posedge aclk) begin
        if (adv) begin
            cmp_a_reg <= pick(quo_a, flg_a, pwm_period_reg);
            cmp_b_reg <= pick(quo_b, flg_b, pwm_period_reg);
            cmp_c_reg <= pick(quo_c, flg_c, pwm_period_reg);
        end
    end

    assign m_compare_a = cmp_a_reg;
    assign m_compare_b = cmp_b_reg;
    assign m_compare_c = cmp_c_reg;

endmodule
`default_nettype wire

// ===== test/pvm_checker.sv =====
// Result checker for the phase voltage modulator: predicts three compare values per request.
// Depends on pvm_pkg; instantiated by the testbench beside the block.
`timescale 1ns / 100ps
module pvm_checker
    import pvm_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic                 s_ready,
    input  wire logic signed [15:0]   s_q_voltage,
    input  wire logic signed [15:0]   s_d_voltage,
    input  wire logic [15:0]          s_elec_angle,
    input  wire logic                 m_valid,
    input  wire logic                 m_ready,
    input  wire logic [PERIOD_W-1:0]  m_compare_a,
    input  wire logic [PERIOD_W-1:0]  m_compare_b,
    input  wire logic [PERIOD_W-1:0]  m_compare_c,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PERIOD_W-1:0]  cfg_wdata,
    output int                        error_count,
    output int                        pending_count
);

    typedef struct {
        logic [PERIOD_W-1:0] a;
        logic [PERIOD_W-1:0] b;
        logic [PERIOD_W-1:0] c;
    } compare_set_t;

    compare_set_t pending_compares[$];
    logic [15:0]  limit_reg;
    logic [15:0]  supply_reg;
    logic [15:0]  zero_reg;
    logic [16:0]  period_reg;

    assign pending_count = pending_compares.size();

    function automatic longint poly_quarter(longint z);
        longint z2;
        longint t;
        z2 = (z * z) >>> 14;
        t  = 10583 - ((1231 * z2) >>> 14);
        t  = 25736 - ((z2 * t) >>> 14);
        t  = (z * t) >>> 14;
        return (t > 16384) ? 64'sd16384 : t;
    endfunction

    function automatic longint stepped_sine(logic [15:0] theta);
        longint k;
        longint p;
        longint r;
        longint m;
        k = (longint'(theta) * SINE_ENTRIES) >>> ANGLE_BITS;
        p = ((k << 16) / SINE_ENTRIES) & 16'hFFFF;
        r = p & 16'h3FFF;
        m = p[14] ? poly_quarter(16384 - r) : poly_quarter(r);
        return p[15] ? -m : m;
    endfunction

    // Arithmetic shift of a signed value rounds toward minus infinity.
    function automatic logic [PERIOD_W-1:0] phase_compare(longint u);
        longint top;
        longint den;
        longint c;
        top = longint'(limit_reg) << 14;
        den = longint'(supply_reg) << 14;
        if (u < 0) u = 0;
        if (u > top) u = top;
        if (den == 0) begin
            c = (u > 0) ? longint'(period_reg) : 0;
        end else begin
            c = (u * longint'(period_reg)) / den;
            if (c > period_reg) c = period_reg;
        end
        return c[PERIOD_W-1:0];
    endfunction

    function automatic compare_set_t predict_compares(longint q, longint d, logic [15:0] ang);
        logic [15:0]  theta;
        longint       sn;
        longint       cs;
        longint       alpha;
        longint       beta;
        longint       half;
        longint       s3b;
        compare_set_t res;
        theta = ang + zero_reg;
        sn    = stepped_sine(theta);
        cs    = stepped_sine(theta + QTR_TURN);
        alpha = d * cs - q * sn;
        beta  = q * cs + d * sn;
        half  = longint'(supply_reg) << 21;
        s3b   = (beta * SQRT3_Q16) >>> 16;
        res.a = phase_compare(alpha + half);
        res.b = phase_compare(((s3b - alpha) >>> 1) + half);
        res.c = phase_compare(((-s3b - alpha) >>> 1) + half);
        return res;
    endfunction

    always @(posedge aclk) begin
        compare_set_t want;
        if (!aresetn) begin
            limit_reg   <= 16'd2560;
            supply_reg  <= 16'd3072;
            zero_reg    <= 16'd0;
            period_reg  <= 17'd1800;
            error_count <= 0;
            pending_compares.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_VOLTAGE_LIMIT: begin
                        limit_reg <= cfg_wdata[15:0];
                    end
                    REG_SUPPLY_VOLTAGE: begin
                        supply_reg <= cfg_wdata[15:0];
                    end
                    REG_ZERO_ANGLE: begin
                        zero_reg <= cfg_wdata[15:0];
                    end
                    REG_PWM_PERIOD: begin
                        period_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready) begin
                pending_compares.push_back(predict_compares(longint'(s_q_voltage),
                    longint'(s_d_voltage), s_elec_angle));
            end
            if (m_valid && m_ready) begin
                if (pending_compares.size() == 0) begin
                    if (error_count < 10) $display("unexpected result %0d %0d %0d",
                        m_compare_a, m_compare_b, m_compare_c);
                    error_count <= error_count + 1;
                end else begin
                    want = pending_compares.pop_front();
                    if (want.a !== m_compare_a || want.b !== m_compare_b
                            || want.c !== m_compare_c) begin
                        if (error_count < 10) $display(
                            "mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                            want.a, want.b, want.c, m_compare_a, m_compare_b, m_compare_c);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
// Top of the phase voltage modulator testbench: clock, reset, stimulus, configuration and verdict.
// Depends on pvm_pkg, phase_voltage_modulator and pvm_checker.
`timescale 1ns / 100ps
module testbench;
    import pvm_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [15:0]   s_q_voltage;
    logic signed [15:0]   s_d_voltage;
    logic [15:0]          s_elec_angle;
    logic                 m_valid;
    logic                 m_ready;
    logic [PERIOD_W-1:0]  m_compare_a;
    logic [PERIOD_W-1:0]  m_compare_b;
    logic [PERIOD_W-1:0]  m_compare_c;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PERIOD_W-1:0]  cfg_wdata;
    int                   error_count;
    int                   pending_count;
    int                   quiet_cycles;
    int                   sent_count;
    bit                   calm_phase;

    phase_voltage_modulator dut (.*);
    pvm_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Receiver stalls in random bursts until the final stretch.
    initial begin
        int burst;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (!calm_phase && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 4);
                m_ready <= 1'b0;
                repeat (burst - 1) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("[phase_voltage_modulator] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain_pipeline();
        while (pending_count != 0) @(posedge aclk);
        repeat (PIPE_DEPTH + 4) @(posedge aclk);
    endtask

    task automatic send_request(logic [15:0] q, logic [15:0] d, logic [15:0] ang);
        int gap;
        if (!calm_phase && $urandom_range(0, 6) == 0) begin
            gap = $urandom_range(1, 4);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_q_voltage  <= q;
        s_d_voltage  <= d;
        s_elec_angle <= ang;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
    endtask

    // Mostly moderate voltages so clamps do not dominate; some full-range extremes.
    task automatic random_requests(int count);
        logic [15:0] q;
        logic [15:0] d;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) == 0) begin
                q = $urandom;
                d = $urandom;
            end else begin
                q = 16'($signed($urandom_range(0, 6000)) - 3000);
                d = 16'($signed($urandom_range(0, 2000)) - 1000);
            end
            send_request(q, d, $urandom);
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        logic [15:0] edge_vals[5];
        edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0100};
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_q_voltage  = '0;
        s_d_voltage  = '0;
        s_elec_angle = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = '0;
        cfg_wdata    = '0;
        calm_phase   = 1'b0;
        sent_count   = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: extremes of voltage and angle at the reset settings.
        for (int i = 0; i < 5; i++) begin
            send_request(edge_vals[i], edge_vals[4 - i], 16'(i * 16'h3FFF));
        end
        send_request(16'h0A00, 16'h0000, 16'hFFFF);
        send_request(16'h0000, 16'h0A00, 16'h4000);
        s_valid <= 1'b0;
        drain_pipeline();

        // Zero supply, zero and maximum period and a limit above the supply.
        write_reg(REG_SUPPLY_VOLTAGE, 17'd0);
        send_request(16'h0200, 16'hFE00, 16'h1234);
        send_request(16'h8000, 16'h8000, 16'h0000);
        s_valid <= 1'b0;
        drain_pipeline();
        write_reg(REG_SUPPLY_VOLTAGE, 17'd3072);
        write_reg(REG_PWM_PERIOD, 17'd0);
        send_request(16'h0400, 16'h0100, 16'h2000);
        s_valid <= 1'b0;
        drain_pipeline();
        write_reg(REG_PWM_PERIOD, 17'h1FFFF);
        write_reg(REG_VOLTAGE_LIMIT, 17'hFFFF);
        write_reg(REG_ZERO_ANGLE, 17'hFFFF);
        send_request(16'h7FFF, 16'h7FFF, 16'h8000);
        send_request(16'h0000, 16'h0000, 16'h0001);
        s_valid <= 1'b0;
        drain_pipeline();

        // Random phases, each under a different setting.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_VOLTAGE_LIMIT, 17'd2560);
                    write_reg(REG_SUPPLY_VOLTAGE, 17'd3072);
                    write_reg(REG_ZERO_ANGLE, 17'd0);
                    write_reg(REG_PWM_PERIOD, 17'd1800);
                end
                1: begin
                    write_reg(REG_SUPPLY_VOLTAGE, 17'd1);
                    write_reg(REG_PWM_PERIOD, 17'd65536);
                end
                2: begin
                    write_reg(REG_VOLTAGE_LIMIT, 17'd0);
                    write_reg(REG_SUPPLY_VOLTAGE, 17'hFFFF);
                end
                default: begin
                    write_reg(REG_VOLTAGE_LIMIT, 17'($urandom));
                    write_reg(REG_SUPPLY_VOLTAGE, 17'($urandom_range(1, 65535)));
                    write_reg(REG_ZERO_ANGLE, 17'($urandom));
                    write_reg(REG_PWM_PERIOD, 17'($urandom_range(1, 65536)));
                end
            endcase
            if (ph == 5) calm_phase = 1'b1;
            random_requests(300);
            drain_pipeline();
        end

        $display("Sent %0d requests over ten register settings, including zero supply,",
            sent_count);
        $display("zero and maximum period, full-scale voltages and all angle quadrants.");
        if (error_count == 0) begin
            $display("[phase_voltage_modulator] OK");
        end else begin
            $display("[phase_voltage_modulator] ERROR");
        end
        $finish;
    end

endmodule
